// ----- design/grg_pkg.sv -----
package grg_pkg;

  localparam int STR_W      = 40;
  localparam int TOTAL_W    = 52;
  localparam int RATIO_W    = 30;
  localparam int HALF_W     = 20;
  localparam int PROD_W     = STR_W + RATIO_W;
  localparam int DIM_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 30;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_ROW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_COL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO    = 3'd4;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

endpackage

// ----- design/grg_ram.sv -----
module grg_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 40
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/grg_heap_ram.sv -----
module grg_heap_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 52
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- design/grid_region_grow_absorb_unit.sv -----
// Seeded region growing over a grid of cell strengths.
// Input channel (in_valid/in_stall): one cell strength per word in row-major
// order, one word per cycle while loading. Cells past rows*cols are ignored.
// The word with in_last_cell set starts a run: in_stall rises while the run
// is in progress.
// A run first clears all MAX_ROWS*MAX_COLS entries of the visited map, one
// entry per cycle. Growth then pops a min-heap kept in a memory with one write
// and two read ports: a pop reads the top and the last entry, then sifts down
// level by level (read the children, compare, write), then runs the absorb
// test (split multiply, compare) and adds the cell when it joins. A neighbor
// off the grid is skipped, an already visited one is checked and dropped, any
// other is marked visited and pushed with a sift-up, level by level.
// Output channel (out_valid/out_stall): one word with the final total per run,
// held in an output register; a stalled word stays unchanged and loading of
// the next grid goes on behind it.
// Configuration (cfg_valid/cfg_ready): cfg_ready is always high; write only
// while no run is in progress.
// Reset (rst_n low, synchronous) restores the register defaults, empties the
// output and starts loading at cell zero. Cell memory contents are not reset.
module grid_region_grow_absorb_unit
  import grg_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [STR_W-1:0]      in_cell_strength,
  input  logic                  in_last_cell,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TOTAL_W-1:0]    out_grown_total,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int PW    = $clog2(CELLS + 1);
  localparam int LW    = AW + 2;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ENT_W = STR_W + RW + CW;
  localparam int LIM_W = 2 * DIM_W;

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_CLR      = 4'd1;
  localparam logic [3:0] S_SEED_RD  = 4'd2;
  localparam logic [3:0] S_SEED     = 4'd3;
  localparam logic [3:0] S_NB_RD    = 4'd4;
  localparam logic [3:0] S_NB_CHK   = 4'd5;
  localparam logic [3:0] S_PUSH_RD  = 4'd6;
  localparam logic [3:0] S_PUSH_CMP = 4'd7;
  localparam logic [3:0] S_POP      = 4'd8;
  localparam logic [3:0] S_POP_W    = 4'd9;
  localparam logic [3:0] S_SD_RD    = 4'd10;
  localparam logic [3:0] S_SD_CMP   = 4'd11;
  localparam logic [3:0] S_MUL      = 4'd12;
  localparam logic [3:0] S_CMP      = 4'd13;
  localparam logic [3:0] S_ADD      = 4'd14;
  localparam logic [3:0] S_OUT      = 4'd15;

  // configuration
  logic [6:0]         rows_cfg_r, cols_cfg_r;
  logic [5:0]         seed_row_cfg_r, seed_col_cfg_r;
  logic [RATIO_W-1:0] ratio_r;

  logic [3:0]         state_r, state_nxt;
  logic [PW-1:0]      load_pos_r, load_pos_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [PW-1:0]      size_r, size_nxt;
  logic [AW-1:0]      hole_r, hole_nxt;
  logic [1:0]         k_r, k_nxt;
  logic [RW-1:0]      cur_row_r, cur_row_nxt, nb_row_r, nb_row_nxt;
  logic [CW-1:0]      cur_col_r, cur_col_nxt, nb_col_r, nb_col_nxt;
  logic [AW-1:0]      nb_addr_r, nb_addr_nxt;
  logic [ENT_W-1:0]   push_r, push_nxt, top_r, top_nxt, last_r, last_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [HALF_W+RATIO_W-1:0] p_lo_r, p_lo_nxt, p_hi_r, p_hi_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [TOTAL_W-1:0] out_total_r, out_total_nxt;

  // memory ports
  logic               cell_we;
  logic [AW-1:0]      cell_raddr;
  logic [STR_W-1:0]   cell_rdata;
  logic               vis_we, vis_wdata;
  logic [AW-1:0]      vis_waddr, vis_raddr;
  logic               vis_rdata;
  logic               heap_we;
  logic [AW-1:0]      heap_waddr, heap_raddr_a, heap_raddr_b;
  logic [ENT_W-1:0]   heap_wdata, heap_rdata_a, heap_rdata_b;

  // derived geometry
  logic [DIM_W-1:0]   rows_w, cols_w, rows_eff, cols_eff, sr_w, sc_w, sr_eff, sc_eff;
  logic [LIM_W-1:0]   cell_lim;
  logic               in_acc;
  logic               nb_in;
  logic [RW-1:0]      nr;
  logic [CW-1:0]      nc;
  logic [LIM_W-1:0]   nb_lin, seed_lin;
  logic [AW-1:0]      parent;
  logic [PW-1:0]      size_m1;
  logic [LW-1:0]      l_w, r_w, size_w;
  logic [ENT_W-1:0]   cand;
  logic [AW-1:0]      cand_idx;
  logic [STR_W-1:0]   top_str;
  logic [PROD_W-1:0]  prod;
  logic [TOTAL_W:0]   sum;

  assign rows_w   = DIM_W'(rows_cfg_r);
  assign cols_w   = DIM_W'(cols_cfg_r);
  assign rows_eff = (rows_w == '0) ? DIM_W'(1) :
                    ((rows_w > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_w);
  assign cols_eff = (cols_w == '0) ? DIM_W'(1) :
                    ((cols_w > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_w);
  assign sr_w     = DIM_W'(seed_row_cfg_r);
  assign sc_w     = DIM_W'(seed_col_cfg_r);
  assign sr_eff   = (sr_w >= rows_eff) ? rows_eff - DIM_W'(1) : sr_w;
  assign sc_eff   = (sc_w >= cols_eff) ? cols_eff - DIM_W'(1) : sc_w;
  assign cell_lim = LIM_W'(rows_eff) * LIM_W'(cols_eff);
  assign seed_lin = LIM_W'(sr_eff) * LIM_W'(cols_eff) + LIM_W'(sc_eff);

  assign in_stall  = (state_r != S_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_grown_total = out_total_r;

  // neighbor in order right, down, left, up
  always_comb begin
    nr    = cur_row_r;
    nc    = cur_col_r;
    nb_in = 1'b0;
    case (k_r)
      2'd0: begin
        nc    = cur_col_r + CW'(1);
        nb_in = (DIM_W'(cur_col_r) + DIM_W'(1)) < cols_eff;
      end
      2'd1: begin
        nr    = cur_row_r + RW'(1);
        nb_in = (DIM_W'(cur_row_r) + DIM_W'(1)) < rows_eff;
      end
      2'd2: begin
        nc    = cur_col_r - CW'(1);
        nb_in = (cur_col_r != '0);
      end
      default: begin
        nr    = cur_row_r - RW'(1);
        nb_in = (cur_row_r != '0);
      end
    endcase
  end

  assign nb_lin  = LIM_W'(nr) * LIM_W'(cols_eff) + LIM_W'(nc);
  assign parent  = (hole_r - AW'(1)) >> 1;
  assign size_m1 = size_r - PW'(1);
  assign l_w     = LW'({hole_r, 1'b1});
  assign r_w     = l_w + LW'(1);
  assign size_w  = LW'(size_r);
  assign top_str = top_r[ENT_W-1 -: STR_W];
  assign prod    = {p_hi_r, {HALF_W{1'b0}}} + PROD_W'(p_lo_r);
  assign sum     = {1'b0, total_r} + (TOTAL_W + 1)'(top_str);

  always_comb begin
    if ((r_w < size_w) && (heap_rdata_b < heap_rdata_a)) begin
      cand     = heap_rdata_b;
      cand_idx = r_w[AW-1:0];
    end else begin
      cand     = heap_rdata_a;
      cand_idx = l_w[AW-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    load_pos_nxt  = load_pos_r;
    clr_nxt       = clr_r;
    size_nxt      = size_r;
    hole_nxt      = hole_r;
    k_nxt         = k_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    nb_row_nxt    = nb_row_r;
    nb_col_nxt    = nb_col_r;
    nb_addr_nxt   = nb_addr_r;
    push_nxt      = push_r;
    top_nxt       = top_r;
    last_nxt      = last_r;
    total_nxt     = total_r;
    p_lo_nxt      = p_lo_r;
    p_hi_nxt      = p_hi_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_total_nxt = out_total_r;

    cell_we      = 1'b0;
    cell_raddr   = nb_lin[AW-1:0];
    vis_we       = 1'b0;
    vis_wdata    = 1'b0;
    vis_waddr    = clr_r;
    vis_raddr    = nb_lin[AW-1:0];
    heap_we      = 1'b0;
    heap_waddr   = hole_r;
    heap_wdata   = push_r;
    heap_raddr_a = parent;
    heap_raddr_b = size_m1[AW-1:0];

    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          cell_we = (LIM_W'(load_pos_r) < cell_lim);
          if (load_pos_r < PW'(CELLS)) begin
            load_pos_nxt = load_pos_r + PW'(1);
          end
          if (in_last_cell) begin
            load_pos_nxt = '0;
            clr_nxt      = '0;
            state_nxt    = S_CLR;
          end
        end
      end
      S_CLR: begin
        vis_we  = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(CELLS - 1)) begin
          state_nxt = S_SEED_RD;
        end
      end
      S_SEED_RD: begin
        cell_raddr = seed_lin[AW-1:0];
        vis_we     = 1'b1;
        vis_wdata  = 1'b1;
        vis_waddr  = seed_lin[AW-1:0];
        state_nxt  = S_SEED;
      end
      S_SEED: begin
        total_nxt   = TOTAL_W'(cell_rdata);
        cur_row_nxt = sr_eff[RW-1:0];
        cur_col_nxt = sc_eff[CW-1:0];
        size_nxt    = '0;
        k_nxt       = 2'd0;
        state_nxt   = S_NB_RD;
      end
      S_NB_RD: begin
        nb_row_nxt  = nr;
        nb_col_nxt  = nc;
        nb_addr_nxt = nb_lin[AW-1:0];
        if (nb_in) begin
          state_nxt = S_NB_CHK;
        end else if (k_r == 2'd3) begin
          state_nxt = S_POP;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_NB_CHK: begin
        if (!vis_rdata) begin
          vis_we    = 1'b1;
          vis_wdata = 1'b1;
          vis_waddr = nb_addr_r;
          push_nxt  = {cell_rdata, nb_row_r, nb_col_r};
          hole_nxt  = size_r[AW-1:0];
          size_nxt  = size_r + PW'(1);
          state_nxt = S_PUSH_RD;
        end else if (k_r == 2'd3) begin
          state_nxt = S_POP;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_NB_RD;
        end
      end
      S_PUSH_RD: begin
        if (hole_r == '0) begin
          heap_we = 1'b1;
          if (k_r == 2'd3) begin
            state_nxt = S_POP;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = S_NB_RD;
          end
        end else begin
          state_nxt = S_PUSH_CMP;
        end
      end
      S_PUSH_CMP: begin
        heap_we = 1'b1;
        if (push_r < heap_rdata_a) begin
          // move parent down, climb
          heap_wdata = heap_rdata_a;
          hole_nxt   = parent;
          state_nxt  = S_PUSH_RD;
        end else if (k_r == 2'd3) begin
          state_nxt = S_POP;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_NB_RD;
        end
      end
      S_POP: begin
        heap_raddr_a = '0;
        if (size_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          size_nxt  = size_m1;
          state_nxt = S_POP_W;
        end
      end
      S_POP_W: begin
        top_nxt  = heap_rdata_a;
        last_nxt = heap_rdata_b;
        hole_nxt = '0;
        state_nxt = (size_r == '0) ? S_MUL : S_SD_RD;
      end
      S_SD_RD: begin
        heap_raddr_a = l_w[AW-1:0];
        heap_raddr_b = r_w[AW-1:0];
        if (l_w >= size_w) begin
          heap_we    = 1'b1;
          heap_wdata = last_r;
          state_nxt  = S_MUL;
        end else begin
          state_nxt = S_SD_CMP;
        end
      end
      S_SD_CMP: begin
        heap_we = 1'b1;
        if (cand < last_r) begin
          heap_wdata = cand;
          hole_nxt   = cand_idx;
          state_nxt  = S_SD_RD;
        end else begin
          heap_wdata = last_r;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        p_lo_nxt  = (HALF_W + RATIO_W)'(top_str[HALF_W-1:0]) * (HALF_W + RATIO_W)'(ratio_r);
        p_hi_nxt  = (HALF_W + RATIO_W)'(top_str[STR_W-1:HALF_W]) *
                    (HALF_W + RATIO_W)'(ratio_r);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if ((total_r != '0) && (prod < PROD_W'(total_r))) begin
          state_nxt = S_ADD;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_ADD: begin
        total_nxt   = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
        cur_row_nxt = top_r[RW+CW-1:CW];
        cur_col_nxt = top_r[CW-1:0];
        k_nxt       = 2'd0;
        state_nxt   = S_NB_RD;
      end
      S_OUT: begin
        // wait for a free output register
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = total_r;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_LOAD;
      load_pos_r     <= '0;
      size_r         <= '0;
      out_valid_r    <= 1'b0;
      total_r        <= '0;
      rows_cfg_r     <= 7'd64;
      cols_cfg_r     <= 7'd64;
      seed_row_cfg_r <= '0;
      seed_col_cfg_r <= '0;
      ratio_r        <= RATIO_W'(1);
    end else begin
      state_r     <= state_nxt;
      load_pos_r  <= load_pos_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ROWS:     rows_cfg_r     <= cfg_data[6:0];
          REG_COLS:     cols_cfg_r     <= cfg_data[6:0];
          REG_SEED_ROW: seed_row_cfg_r <= cfg_data[5:0];
          REG_SEED_COL: seed_col_cfg_r <= cfg_data[5:0];
          REG_RATIO:    ratio_r        <= cfg_data[RATIO_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    clr_r       <= clr_nxt;
    hole_r      <= hole_nxt;
    k_r         <= k_nxt;
    cur_row_r   <= cur_row_nxt;
    cur_col_r   <= cur_col_nxt;
    nb_row_r    <= nb_row_nxt;
    nb_col_r    <= nb_col_nxt;
    nb_addr_r   <= nb_addr_nxt;
    push_r      <= push_nxt;
    top_r       <= top_nxt;
    last_r      <= last_nxt;
    p_lo_r      <= p_lo_nxt;
    p_hi_r      <= p_hi_nxt;
    out_total_r <= out_total_nxt;
  end

  grg_ram #(.DEPTH(CELLS), .AW(AW), .DW(STR_W)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (load_pos_r[AW-1:0]),
    .wdata (in_cell_strength),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  grg_ram #(.DEPTH(CELLS), .AW(AW), .DW(1)) u_vis_ram (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (vis_raddr),
    .rdata (vis_rdata)
  );

  grg_heap_ram #(.DEPTH(CELLS), .AW(AW), .DW(ENT_W)) u_heap_ram (
    .clk     (clk),
    .we      (heap_we),
    .waddr   (heap_waddr),
    .wdata   (heap_wdata),
    .raddr_a (heap_raddr_a),
    .raddr_b (heap_raddr_b),
    .rdata_a (heap_rdata_a),
    .rdata_b (heap_rdata_b)
  );

endmodule

// ----- design/grg_checker.sv -----
module grg_checker
  import grg_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_last_cell,
  input logic               out_valid,
  input logic               out_stall,
  input logic [TOTAL_W-1:0] out_grown_total
);

  // a run holds off the input
  a_run_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_cell) |=> in_stall)
    else $error("input not stalled after last cell");

  // loading words go one per cycle
  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_last_cell) |=> !in_stall)
    else $error("stall raised during loading");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_grown_total)))
    else $error("stalled output word changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind grid_region_grow_absorb_unit grg_checker u_grg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_last_cell    (in_last_cell),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_grown_total (out_grown_total)
);

// ----- tb/testbench.sv -----
module testbench;
  import grg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELL_CNT = DEF_MAX_ROWS * DEF_MAX_COLS;
  localparam int STALL_LIMIT = 3000000;
  localparam int WORD_TARGET = 800;
  localparam int LONG_HOLD = 12000;

  typedef enum {ST_CFG, ST_WORD} step_kind_t;
  typedef struct {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [STR_W-1:0]     val;
    bit                   last;
    bit                   typed;
    logic [TOTAL_W-1:0]   want;
  } step_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [STR_W-1:0]      in_cell_strength;
  logic                  in_last_cell;
  logic                  out_valid;
  logic                  out_stall;
  logic [TOTAL_W-1:0]    out_grown_total;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  grid_region_grow_absorb_unit dut (.*);

  // model state
  logic [STR_W-1:0]   strength_mem [CELL_CNT];
  bit                 loaded       [CELL_CNT];
  bit                 seen_map     [CELL_CNT];
  int                 load_pos;
  logic [6:0]         rows_reg, cols_reg;
  logic [5:0]         seed_row_reg, seed_col_reg;
  logic [RATIO_W-1:0] ratio_reg;

  logic [TOTAL_W-1:0] pending_totals[$];
  int errors, words_sent, totals_seen, grids_sent, quiet_cycles;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report(input string what, input logic [TOTAL_W-1:0] got,
                        input logic [TOTAL_W-1:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int rows_in_use();
    return rows_reg < 1 ? 1 : (rows_reg > DEF_MAX_ROWS ? DEF_MAX_ROWS : int'(rows_reg));
  endfunction

  function automatic int cols_in_use();
    return cols_reg < 1 ? 1 : (cols_reg > DEF_MAX_COLS ? DEF_MAX_COLS : int'(cols_reg));
  endfunction

  // best-first growth: the frontier min by (strength, index) is what a heap pops
  function automatic logic [TOTAL_W-1:0] grown_region_total();
    int rows, cols, sr, sc, seed, idx, r, c, k, best;
    int frontier[$];
    int nbr[4];
    bit ok[4];
    bit first;
    logic [TOTAL_W-1:0] total;
    logic [71:0] prod;
    rows = rows_in_use();
    cols = cols_in_use();
    sr = seed_row_reg >= rows ? rows - 1 : int'(seed_row_reg);
    sc = seed_col_reg >= cols ? cols - 1 : int'(seed_col_reg);
    seed = sr * cols + sc;
    foreach (seen_map[i]) seen_map[i] = 0;
    total = strength_mem[seed];
    seen_map[seed] = 1;
    frontier.insert(frontier.size(), seed);
    first = 1;
    while (frontier.size() > 0) begin
      best = 0;
      for (k = 1; k < frontier.size(); k++) begin
        if (strength_mem[frontier[k]] < strength_mem[frontier[best]] ||
            (strength_mem[frontier[k]] == strength_mem[frontier[best]] &&
             frontier[k] < frontier[best]))
          best = k;
      end
      idx = frontier[best];
      frontier.delete(best);
      if (!first) begin
        prod = strength_mem[idx];
        prod = prod * ratio_reg;
        if (!(prod < total)) continue;
        total = (TOTAL_MAX - total < strength_mem[idx]) ? TOTAL_MAX
                                                       : total + strength_mem[idx];
      end
      first = 0;
      r = idx / cols;
      c = idx % cols;
      ok[0] = c + 1 < cols; nbr[0] = idx + 1;
      ok[1] = r + 1 < rows; nbr[1] = idx + cols;
      ok[2] = c > 0;        nbr[2] = idx - 1;
      ok[3] = r > 0;        nbr[3] = idx - cols;
      for (k = 0; k < 4; k++) begin
        if (ok[k] && !seen_map[nbr[k]]) begin
          seen_map[nbr[k]] = 1;
          frontier.insert(frontier.size(), nbr[k]);
        end
      end
    end
    return total;
  endfunction

  // load one word; returns 1 with the total when the word closes a grid
  function automatic bit load_cell(input logic [STR_W-1:0] s, input bit last,
                                   output logic [TOTAL_W-1:0] total);
    if (load_pos < rows_in_use() * cols_in_use()) begin
      strength_mem[load_pos] = s;
      loaded[load_pos] = 1;
    end
    if (load_pos < CELL_CNT) load_pos++;
    if (!last) return 0;
    total = grown_region_total();
    load_pos = 0;
    return 1;
  endfunction

  task automatic send_word(input logic [STR_W-1:0] s, input bit last, input bit typed,
                           input logic [TOTAL_W-1:0] want);
    int gap;
    logic [TOTAL_W-1:0] total;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cell_strength <= s;
    in_last_cell <= last;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (load_cell(s, last, total)) begin
      pending_totals.insert(pending_totals.size(), typed ? want : total);
      grids_sent++;
    end
  endtask

  // idle: all totals back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_totals.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ROWS:     rows_reg = d[6:0];
      REG_COLS:     cols_reg = d[6:0];
      REG_SEED_ROW: seed_row_reg = d[5:0];
      REG_SEED_COL: seed_col_reg = d[5:0];
      REG_RATIO:    ratio_reg = d[RATIO_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: per-word stall, one long hold after the fourth total so that
  // the next two grids back up and stall the input
  int stall_left, out_words;
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      out_words <= 0;
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      out_words <= out_words + 1;
      stall_left <= (out_words == 3) ? LONG_HOLD : (calm ? 0 : $urandom_range(0, 6));
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      totals_seen++;
      if (pending_totals.size() == 0) report("unexpected total", out_grown_total, '0);
      else begin
        if (out_grown_total !== pending_totals[0])
          report("grown_total", out_grown_total, pending_totals[0]);
        void'(pending_totals.pop_front());
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  step_t steps[$];

  function automatic void add_step(input step_t s);
    steps.insert(steps.size(), s);
  endfunction

  function automatic step_t cfg_step(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [STR_W-1:0] v);
    return '{ST_CFG, idx, v, 1'b0, 1'b0, '0};
  endfunction

  function automatic step_t word_step(input logic [STR_W-1:0] v, input bit last,
                                      input bit typed, input logic [TOTAL_W-1:0] want);
    return '{ST_WORD, REG_ROWS, v, last, typed, want};
  endfunction

  function automatic logic [STR_W-1:0] pick_strength(input int mode);
    case (mode)
      0: return STR_W'({$urandom, $urandom});
      1: return STR_W'($urandom_range(0, 20));
      2: return ($urandom_range(0, 3) == 0) ? {STR_W{1'b1}}
                                            : STR_W'($urandom_range(0, 1000));
      default: return $urandom_range(0, 1) ? STR_W'({$urandom, $urandom})
                                           : STR_W'($urandom_range(0, 50));
    endcase
  endfunction

  initial begin
    int n, len, mode, kind, p;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cell_strength = '0;
    in_last_cell = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_ROWS;
    cfg_data = '0;
    errors = 0;
    words_sent = 0;
    totals_seen = 0;
    grids_sent = 0;
    calm = 0;
    load_pos = 0;
    rows_reg = 7'd64;
    cols_reg = 7'd64;
    seed_row_reg = '0;
    seed_col_reg = '0;
    ratio_reg = 1;
    foreach (loaded[i]) loaded[i] = 0;
    foreach (strength_mem[i]) strength_mem[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single cell, seed far outside the grid
    add_step(cfg_step(REG_ROWS, 1));
    add_step(cfg_step(REG_COLS, 1));
    add_step(cfg_step(REG_SEED_ROW, 5));
    add_step(cfg_step(REG_SEED_COL, 63));
    add_step(cfg_step(REG_RATIO, 1));
    add_step(word_step({STR_W{1'b1}}, 1, 1, {STR_W{1'b1}}));
    add_step(word_step(0, 1, 1, 0));
    add_step(word_step(12345, 1, 1, 12345));
    // 2x2 with zero ratio: everything joins once the total is nonzero
    add_step(cfg_step(REG_ROWS, 2));
    add_step(cfg_step(REG_COLS, 2));
    add_step(cfg_step(REG_SEED_ROW, 0));
    add_step(cfg_step(REG_SEED_COL, 0));
    add_step(cfg_step(REG_RATIO, 0));
    add_step(word_step(5, 0, 0, 0));
    add_step(word_step(6, 0, 0, 0));
    add_step(word_step(7, 0, 0, 0));
    add_step(word_step(8, 1, 1, 26));
    add_step(word_step(0, 0, 0, 0));
    add_step(word_step(9, 0, 0, 0));
    add_step(word_step(9, 0, 0, 0));
    add_step(word_step(9, 1, 1, 0));
    // extra cells past the grid are dropped
    add_step(word_step(1, 0, 0, 0));
    add_step(word_step(2, 0, 0, 0));
    add_step(word_step(3, 0, 0, 0));
    add_step(word_step(4, 0, 0, 0));
    add_step(word_step(100, 0, 0, 0));
    add_step(word_step(200, 1, 1, 10));
    // short grid reuses the cells of the previous one
    add_step(word_step(50, 1, 1, 59));
    add_step(cfg_step(REG_RATIO, {RATIO_W{1'b1}}));
    add_step(word_step(10, 0, 0, 0));
    add_step(word_step(0, 0, 0, 0));
    add_step(word_step(0, 0, 0, 0));
    add_step(word_step(1, 1, 1, 10));
    add_step(cfg_step(REG_RATIO, 1));
    add_step(word_step(4, 0, 0, 0));
    add_step(word_step(3, 0, 0, 0));
    add_step(word_step(5, 0, 0, 0));
    add_step(word_step(1, 1, 0, 0));

    foreach (steps[i]) begin
      if (steps[i].kind == ST_CFG) begin
        if (i == 0 || steps[i-1].kind != ST_CFG) drain();
        write_reg(steps[i].idx, steps[i].val[CFG_DATA_W-1:0]);
        if (i + 1 == steps.size() || steps[i+1].kind != ST_CFG) end_writes();
      end else begin
        send_word(steps[i].val, steps[i].last, steps[i].typed, steps[i].want);
      end
    end

    // random grids; a few long and wide shapes up front
    for (int g = 0; words_sent < WORD_TARGET || g < 4; g++) begin
      calm = ($urandom_range(0, 3) == 0);
      if (g < 3 || $urandom_range(0, 2) == 0) begin
        drain();
        kind = $urandom_range(0, 19);
        if (g == 0) begin
          write_reg(REG_ROWS, 64);
          write_reg(REG_COLS, 3);
        end else if (g == 1 || kind == 0) begin
          write_reg(REG_ROWS, $urandom_range(0, 127));
          write_reg(REG_COLS, $urandom_range(1, 3));
        end else if (g == 2 || kind == 1) begin
          write_reg(REG_ROWS, $urandom_range(0, 3));
          write_reg(REG_COLS, $urandom_range(64, 127));
        end else begin
          write_reg(REG_ROWS, $urandom_range(1, 8));
          write_reg(REG_COLS, $urandom_range(1, 8));
        end
        write_reg(REG_SEED_ROW, $urandom_range(0, 5) == 0 ? $urandom_range(0, 63)
                                                            : $urandom_range(0, 7));
        write_reg(REG_SEED_COL, $urandom_range(0, 5) == 0 ? $urandom_range(0, 63)
                                                            : $urandom_range(0, 7));
        case ($urandom_range(0, 5))
          0: write_reg(REG_RATIO, 0);
          1: write_reg(REG_RATIO, 1);
          2: write_reg(REG_RATIO, $urandom_range(2, 4));
          3: write_reg(REG_RATIO, {RATIO_W{1'b1}});
          default: write_reg(REG_RATIO, CFG_DATA_W'($urandom));
        endcase
        end_writes();
      end
      n = rows_in_use() * cols_in_use();
      len = n;
      p = $urandom_range(0, 9);
      if (p == 0) len = n + $urandom_range(1, 3);
      else if (p == 1) begin
        len = $urandom_range(1, n);
        for (int i = 0; i < n; i++) if (!loaded[i]) len = n;
      end
      mode = $urandom_range(0, 3);
      for (int i = 0; i < len; i++)
        send_word(pick_strength(mode), i == len - 1, 0, '0);
    end

    in_valid <= 1'b0;
    while (pending_totals.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d cell words over %0d grids, %0d totals returned",
             words_sent, grids_sent, totals_seen);
    $display("included edge grids, seed clamping, extra cells and a long output hold");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
